>>> rtl/loop_stall_and_frame_rate_monitor_core_assert.svh
// Assertion macros for the loop stall and frame rate monitor.
// Used by the core; expects clk_i and rst_ni in the including scope.
`ifndef LOOP_STALL_AND_FRAME_RATE_MONITOR_CORE_ASSERT_SVH
`define LOOP_STALL_AND_FRAME_RATE_MONITOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LSFRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LSFRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LSFRM_ASSERT(lbl, prop, msg)
`define LSFRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/lsfrm_pkg.sv
// Package for the loop stall and frame rate monitor.
// Holds field widths, request and register codes and arithmetic constants.
package lsfrm_pkg;

  localparam int unsigned RATE_FRAC_BITS_DEF = 8;

  localparam int unsigned TS_W      = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned FPS_W     = 24;
  localparam int unsigned BUSY_W    = 7;
  localparam int unsigned IN_DATA_W  = 2 * TS_W;
  localparam int unsigned OUT_DATA_W = 3 * TS_W + FPS_W + BUSY_W + 1;

  localparam int unsigned MS_W     = 10;
  localparam int unsigned PROD_W   = TS_W + MS_W;
  localparam int unsigned CNT_W    = 5;

  localparam logic [MS_W-1:0]   MS_PER_SEC = MS_W'(1000);
  localparam logic [BUSY_W-1:0] PCT_SCALE  = BUSY_W'(100);
  localparam logic [FPS_W-1:0]  FPS_MAX    = {FPS_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_LOOP_END   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW_BEGIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRAW_END   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESTART    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_STALL_WIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIM  = 2'd2;

  localparam logic [CFG_W-1:0] STALL_WIN_RST = 16'd1000;
  localparam logic [CFG_W-1:0] RATE_WIN_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] SKIP_LIM_RST  = 16'd50;

endpackage

>>> rtl/loop_stall_and_frame_rate_monitor_core.sv
// Channel   | Dir | Transfer          | Payload
// s_axis    | in  | tvalid & tready   | tuser: req_type; tdata: now_ms, loop_start_ms
// m_axis    | out | tvalid & tready   | tdata: statistics of one event
// cfg       | in  | valid_i & ready_o | index_i: register, data_i: value
// A draw begin, draw end or restart passes the diff, update and output states; a loop end
// adds the roll state, and one that closes a rate window may add the frame rate and busy
// share divisions: one shared divider, one quotient bit per cycle, 24 bits for the rate,
// 7 for the busy share. The next transfer is taken while a result waits on m_axis.
// Reset is asynchronous and active low; all statistics and registers return to defaults.
`include "loop_stall_and_frame_rate_monitor_core_assert.svh"

module loop_stall_and_frame_rate_monitor_core #(
  parameter int unsigned RATE_FRAC_BITS = lsfrm_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: now_ms [31:0], loop_start_ms [63:32]
  input  logic [lsfrm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: req_type [1:0]
  input  logic [lsfrm_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: worst_stall_ms [31:0], frames_per_sec_q8 [55:32], total_draws [87:56],
  // total_loops [119:88], busy_percent [126:120], skip_optional [127]
  output logic [lsfrm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lsfrm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lsfrm_pkg::CFG_W-1:0]        cfg_data_i
);
  import lsfrm_pkg::*;

  localparam int unsigned NUM_W = PROD_W + RATE_FRAC_BITS;
  localparam int unsigned QW    = FPS_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_UPD  = 4'd2;
  localparam logic [3:0] ST_ROLL = 4'd3;
  localparam logic [3:0] ST_FMUL = 4'd4;
  localparam logic [3:0] ST_FSET = 4'd5;
  localparam logic [3:0] ST_FDIV = 4'd6;
  localparam logic [3:0] ST_BMUL = 4'd7;
  localparam logic [3:0] ST_BSET = 4'd8;
  localparam logic [3:0] ST_BDIV = 4'd9;
  localparam logic [3:0] ST_CLR  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]        state_q;
  logic [CFG_W-1:0]  stall_win_q, rate_win_q, skip_lim_q;

  logic [TS_W-1:0]   worst_q, latest_q, swb_q, loops_q, draws_q, dbt_q;
  logic [TS_W-1:0]   wdt_q, calls_q, wlt_q, rwb_q;
  logic [FPS_W-1:0]  fps_q;
  logic [BUSY_W-1:0] busy_q;

  logic [REQ_W-1:0]  req_q;
  logic [TS_W-1:0]   now_q, start_q, dur_q, sel_q, rel_q;
  logic [PROD_W-1:0] prod_q;
  logic [TS_W-1:0]   rem_q, div_q;
  logic [QW-1:0]     sh_q;
  logic [CNT_W-1:0]  cnt_q;

  logic                      m_valid_q;
  logic [OUT_DATA_W-1:0]     m_data_q;

  logic [NUM_W-1:0]  fnum;
  logic [TS_W-1:0]   fnum_hi;
  logic [TS_W:0]     r2, rdiff;
  logic              ge;
  logic [TS_W-1:0]   rem_nx;
  logic [QW-1:0]     sh_nx;
  logic [BUSY_W-1:0] bq;
  logic [TS_W-1:0]   wlt_sum;
  logic              in_div;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign fnum    = NUM_W'(prod_q) << RATE_FRAC_BITS;
  assign fnum_hi = TS_W'(fnum >> QW);
  assign r2      = {rem_q, sh_q[QW-1]};
  assign ge      = (r2 >= {1'b0, div_q});
  assign rdiff   = r2 - {1'b0, div_q};
  assign rem_nx  = ge ? rdiff[TS_W-1:0] : r2[TS_W-1:0];
  assign sh_nx   = {sh_q[QW-2:0], ge};
  assign bq      = sh_nx[BUSY_W-1:0];
  assign wlt_sum = wlt_q + dur_q;
  assign in_div  = (state_q == ST_FDIV) || (state_q == ST_BDIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_valid_q   <= 1'b0;
      stall_win_q <= STALL_WIN_RST;
      rate_win_q  <= RATE_WIN_RST;
      skip_lim_q  <= SKIP_LIM_RST;
      worst_q     <= '0;
      latest_q    <= '0;
      swb_q       <= '0;
      loops_q     <= '0;
      draws_q     <= '0;
      dbt_q       <= '0;
      wdt_q       <= '0;
      calls_q     <= '0;
      wlt_q       <= '0;
      rwb_q       <= '0;
      fps_q       <= '0;
      busy_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_STALL_WIN: stall_win_q <= cfg_data_i;
          CFG_RATE_WIN:  rate_win_q  <= cfg_data_i;
          CFG_SKIP_LIM:  skip_lim_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: state_q <= ST_UPD;
        ST_UPD: begin
          case (req_q)
            REQ_LOOP_END: begin
              loops_q  <= loops_q + 1'b1;
              latest_q <= dur_q;
              if (sel_q > TS_W'(stall_win_q)) begin
                worst_q <= dur_q;
                swb_q   <= now_q;
              end else if (dur_q > worst_q) begin
                worst_q <= dur_q;
              end
              wlt_q   <= wlt_sum;
              state_q <= ST_ROLL;
            end
            REQ_DRAW_BEGIN: begin
              dbt_q   <= now_q;
              state_q <= ST_OUT;
            end
            REQ_DRAW_END: begin
              draws_q <= draws_q + 1'b1;
              calls_q <= calls_q + 1'b1;
              wdt_q   <= wdt_q + dur_q;
              state_q <= ST_OUT;
            end
            default: begin
              worst_q <= '0;
              swb_q   <= now_q;
              rwb_q   <= now_q;
              loops_q <= '0;
              draws_q <= '0;
              fps_q   <= '0;
              busy_q  <= '0;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_ROLL: begin
          if (wdt_q > wlt_q) begin
            wdt_q <= wlt_q;
          end
          state_q <= (rel_q >= TS_W'(rate_win_q)) ? ST_FMUL : ST_OUT;
        end
        ST_FMUL: state_q <= ST_FSET;
        ST_FSET: begin
          if (rel_q == '0) begin
            state_q <= ST_BMUL;
          end else if (fnum_hi >= rel_q) begin
            fps_q   <= FPS_MAX;
            state_q <= ST_BMUL;
          end else begin
            cnt_q   <= CNT_W'(QW - 1);
            state_q <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            fps_q   <= sh_nx;
            state_q <= ST_BMUL;
          end
        end
        ST_BMUL: state_q <= (wlt_q == '0) ? ST_CLR : ST_BSET;
        ST_BSET: begin
          cnt_q   <= CNT_W'(BUSY_W - 1);
          state_q <= ST_BDIV;
        end
        ST_BDIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            busy_q  <= (bq > PCT_SCALE) ? PCT_SCALE : bq;
            state_q <= ST_CLR;
          end
        end
        ST_CLR: begin
          calls_q <= '0;
          wdt_q   <= '0;
          wlt_q   <= '0;
          rwb_q   <= now_q;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        req_q   <= s_axis_tuser;
        now_q   <= s_axis_tdata[TS_W-1:0];
        start_q <= s_axis_tdata[IN_DATA_W-1:TS_W];
      end
      ST_DIFF: begin
        dur_q <= now_q - ((req_q == REQ_LOOP_END) ? start_q : dbt_q);
        sel_q <= now_q - swb_q;
        rel_q <= now_q - rwb_q;
      end
      ST_FMUL: begin
        prod_q <= PROD_W'(calls_q) * PROD_W'(MS_PER_SEC);
        div_q  <= rel_q;
      end
      ST_FSET: begin
        rem_q <= fnum_hi;
        sh_q  <= fnum[QW-1:0];
      end
      ST_FDIV, ST_BDIV: begin
        rem_q <= rem_nx;
        sh_q  <= sh_nx;
      end
      ST_BMUL: begin
        prod_q <= PROD_W'(wdt_q) * PROD_W'(PCT_SCALE);
        div_q  <= wlt_q;
      end
      ST_BSET: begin
        rem_q <= prod_q[BUSY_W+TS_W-1:BUSY_W];
        sh_q  <= {prod_q[BUSY_W-1:0], {(QW-BUSY_W){1'b0}}};
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {(latest_q > TS_W'(skip_lim_q)), busy_q, loops_q, draws_q,
                       fps_q, worst_q};
        end
      end
      default: ;
    endcase
  end

  `LSFRM_ASSERT(a_busy_range, busy_q <= PCT_SCALE, "busy share above 100")
  `LSFRM_ASSERT(a_div_rem, in_div |-> rem_q < div_q, "divider remainder not below divisor")
  `LSFRM_ASSERT(a_clamp, (state_q == ST_FMUL) |-> wdt_q <= wlt_q, "draw time above loop time")
  `LSFRM_ASSERT(a_accept, (s_axis_tvalid && s_axis_tready) |=> state_q == ST_DIFF, "no start")

endmodule

>>> sim/loop_stall_and_frame_rate_monitor_core_checker.sv
// Checker for the loop stall and frame rate monitor: predicts the statistics of each event
// and compares them with the result transfers. Depends on lsfrm_pkg.
`timescale 1ns / 1ps

module loop_stall_and_frame_rate_monitor_core_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // tdata: now_ms [31:0], loop_start_ms [63:32]
  input  logic [lsfrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type [1:0]
  input  logic [lsfrm_pkg::REQ_W-1:0]      s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: worst_stall_ms, frames_per_sec_q8, total_draws, total_loops, busy_percent,
  // skip_optional, from the lowest bit up
  input  logic [lsfrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [lsfrm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsfrm_pkg::CFG_W-1:0]      cfg_data_i,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               rollovers_o
);
  import lsfrm_pkg::*;

  typedef struct packed {
    logic              skip;
    logic [BUSY_W-1:0] busy;
    logic [TS_W-1:0]   loops;
    logic [TS_W-1:0]   draws;
    logic [FPS_W-1:0]  fps;
    logic [TS_W-1:0]   worst;
  } event_stats_t;

  logic [CFG_W-1:0]  stall_win;
  logic [CFG_W-1:0]  rate_win;
  logic [CFG_W-1:0]  skip_lim;

  logic [TS_W-1:0]   worst_stall;
  logic [TS_W-1:0]   last_stall;
  logic [TS_W-1:0]   stall_begin;
  logic [TS_W-1:0]   loop_count;
  logic [TS_W-1:0]   draw_count;
  logic [TS_W-1:0]   draw_started;
  logic [TS_W-1:0]   win_draw_ms;
  logic [TS_W-1:0]   win_draw_calls;
  logic [TS_W-1:0]   win_loop_ms;
  logic [TS_W-1:0]   rate_begin;
  logic [FPS_W-1:0]  fps;
  logic [BUSY_W-1:0] busy;

  event_stats_t expected_stats_q[$];

  task automatic predict_event(input logic [REQ_W-1:0] req, input logic [TS_W-1:0] now_ms,
                               input logic [TS_W-1:0] start_ms, output event_stats_t stats);
    logic [TS_W-1:0] loop_ms;
    logic [TS_W-1:0] elapsed;
    logic [63:0]     quot;
    case (req)
      REQ_LOOP_END: begin
        loop_ms    = now_ms - start_ms;
        loop_count = loop_count + 1;
        last_stall = loop_ms;
        if (loop_ms > worst_stall) worst_stall = loop_ms;
        elapsed = now_ms - stall_begin;
        if (elapsed > TS_W'(stall_win)) begin
          worst_stall = loop_ms;
          stall_begin = now_ms;
        end
        win_loop_ms = win_loop_ms + loop_ms;
        if (win_draw_ms > win_loop_ms) win_draw_ms = win_loop_ms;
        elapsed = now_ms - rate_begin;
        if (elapsed >= TS_W'(rate_win)) begin
          rollovers_o++;
          if (elapsed != '0) begin
            quot = ((64'(win_draw_calls) * 64'(MS_PER_SEC)) << RATE_FRAC_BITS_DEF)
                   / 64'(elapsed);
            fps  = (quot > 64'(FPS_MAX)) ? FPS_MAX : quot[FPS_W-1:0];
          end
          if (win_loop_ms != '0) begin
            quot = (64'(win_draw_ms) * 64'(PCT_SCALE)) / 64'(win_loop_ms);
            busy = (quot > 64'(PCT_SCALE)) ? PCT_SCALE : quot[BUSY_W-1:0];
          end
          win_draw_calls = '0;
          win_draw_ms    = '0;
          win_loop_ms    = '0;
          rate_begin     = now_ms;
        end
      end
      REQ_DRAW_BEGIN: draw_started = now_ms;
      REQ_DRAW_END: begin
        draw_count     = draw_count + 1;
        win_draw_calls = win_draw_calls + 1;
        win_draw_ms    = win_draw_ms + (now_ms - draw_started);
      end
      default: begin
        worst_stall = '0;
        stall_begin = now_ms;
        rate_begin  = now_ms;
        loop_count  = '0;
        draw_count  = '0;
        fps         = '0;
        busy        = '0;
      end
    endcase
    stats.worst = worst_stall;
    stats.fps   = fps;
    stats.draws = draw_count;
    stats.loops = loop_count;
    stats.busy  = busy;
    stats.skip  = last_stall > TS_W'(skip_lim);
  endtask

  task automatic check_field(input string name, input logic [TS_W-1:0] want,
                             input logic [TS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    event_stats_t want;
    event_stats_t got;
    if (!rst_ni) begin
      stall_win      = STALL_WIN_RST;
      rate_win       = RATE_WIN_RST;
      skip_lim       = SKIP_LIM_RST;
      worst_stall    = '0;
      last_stall     = '0;
      stall_begin    = '0;
      loop_count     = '0;
      draw_count     = '0;
      draw_started   = '0;
      win_draw_ms    = '0;
      win_draw_calls = '0;
      win_loop_ms    = '0;
      rate_begin     = '0;
      fps            = '0;
      busy           = '0;
      expected_stats_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STALL_WIN: stall_win = cfg_data_i;
          CFG_RATE_WIN:  rate_win  = cfg_data_i;
          CFG_SKIP_LIM:  skip_lim  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(s_axis_tuser, s_axis_tdata[TS_W-1:0], s_axis_tdata[2*TS_W-1:TS_W], want);
        expected_stats_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_stats_q.size() == 0) begin
          $error("result transfer with no event waiting for it");
          mismatches_o++;
        end else begin
          want = expected_stats_q.pop_front();
          check_field("worst_stall_ms", want.worst, got.worst);
          check_field("frames_per_sec_q8", TS_W'(want.fps), TS_W'(got.fps));
          check_field("total_draws", want.draws, got.draws);
          check_field("total_loops", want.loops, got.loops);
          check_field("busy_percent", TS_W'(want.busy), TS_W'(got.busy));
          check_field("skip_optional", TS_W'(want.skip), TS_W'(got.skip));
          checked_o++;
        end
      end
    end
    pending_o = expected_stats_q.size();
  end

endmodule

>>> sim/loop_stall_and_frame_rate_monitor_core_test.sv
// Testbench top for the loop stall and frame rate monitor: drives event and register
// transfers with random gaps and stalls, and gives the verdict from the checker's counts.
// Depends on lsfrm_pkg, the core and loop_stall_and_frame_rate_monitor_core_checker.
`timescale 1ns / 1ps

module loop_stall_and_frame_rate_monitor_core_test;
  import lsfrm_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = REQ_LOOP_END;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_STALL_WIN;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int rollover_count;

  logic [TS_W-1:0] clock_ms      = '0;
  int unsigned     max_step      = 4;
  bit              calm_src      = 1'b0;
  bit              calm_sink     = 1'b0;
  bit              sink_took     = 1'b0;
  int unsigned     sink_wait     = 2;
  int              events_sent   = 0;
  int              settings_used = 1;

  loop_stall_and_frame_rate_monitor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  loop_stall_and_frame_rate_monitor_core_checker stats_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatch_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count),
    .rollovers_o   (rollover_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("loop_stall_and_frame_rate_monitor_core verification failed");
    $finish;
  end

  // After each result transfer the sink draws a new stall length.
  always @(posedge clk_i) sink_took <= m_axis_tvalid && m_axis_tready;

  always @(negedge clk_i) begin
    if (sink_took) sink_wait = calm_sink ? 0 : $urandom_range(0, 16);
    if (sink_wait > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_event(input logic [REQ_W-1:0] req, input logic [TS_W-1:0] now_ms,
                            input logic [TS_W-1:0] start_ms);
    int unsigned gap;
    gap = calm_src ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {start_ms, now_ms};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    events_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] stall_cfg, input logic [CFG_W-1:0] rate_cfg,
                           input logic [CFG_W-1:0] skip_cfg);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    write_reg(CFG_STALL_WIN, stall_cfg);
    write_reg(CFG_RATE_WIN, rate_cfg);
    write_reg(CFG_SKIP_LIM, skip_cfg);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic advance_clock();
    clock_ms = clock_ms + TS_W'($urandom_range(0, max_step));
  endtask

  // One application loop (optional draws, then the loop end), a random event, a restart
  // or a clock jump. A burst packs many draw ends into one ms so the frame rate saturates.
  task automatic run_frame(input bit burst);
    logic [TS_W-1:0] begun_ms;
    int unsigned     draws;
    int unsigned     pick;
    pick = burst ? 99 : $urandom_range(0, 99);
    if (pick < 8) begin
      send_event(REQ_W'($urandom), $urandom, $urandom);
    end else if (pick < 10) begin
      send_event(REQ_RESTART, clock_ms, $urandom);
    end else if (pick < 12) begin
      clock_ms = $urandom;
    end else if (burst) begin
      clock_ms = clock_ms + 1;
      send_event(REQ_LOOP_END, clock_ms, clock_ms);
      draws = $urandom_range(66, 90);
      for (int i = 0; i < draws; i++) send_event(REQ_DRAW_END, clock_ms, $urandom);
      send_event(REQ_LOOP_END, clock_ms + 1, clock_ms);
      clock_ms = clock_ms + 1;
    end else begin
      begun_ms = clock_ms;
      draws = $urandom_range(0, 3);
      for (int i = 0; i < draws; i++) begin
        advance_clock();
        send_event(REQ_DRAW_BEGIN, clock_ms, $urandom);
        advance_clock();
        send_event(REQ_DRAW_END, clock_ms, $urandom);
      end
      advance_clock();
      send_event(REQ_LOOP_END, clock_ms, begun_ms);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] stall_cfg;
    logic [CFG_W-1:0] rate_cfg;
    logic [CFG_W-1:0] skip_cfg;
    int               frame_idx;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Register defaults: stall and rate windows of 1000 ms, skip limit 50 ms.
    send_event(REQ_LOOP_END, 32'd0, 32'd0);
    send_event(REQ_DRAW_BEGIN, 32'd10, 32'd0);
    send_event(REQ_DRAW_END, 32'd30, 32'd0);
    send_event(REQ_LOOP_END, 32'd40, 32'd0);
    send_event(REQ_LOOP_END, 32'd100, 32'd40);
    // A draw end without a new draw begin, then a short loop that clamps the draw time.
    send_event(REQ_DRAW_END, 32'd120, 32'd0);
    send_event(REQ_LOOP_END, 32'd125, 32'd120);
    // Both windows expire; then a rollover with no loop time in the window.
    send_event(REQ_LOOP_END, 32'd1100, 32'd1000);
    send_event(REQ_LOOP_END, 32'd2100, 32'd2100);
    send_event(REQ_RESTART, 32'd2200, 32'hFFFF_FFFF);
    send_event(REQ_DRAW_BEGIN, 32'd2300, 32'd0);
    send_event(REQ_DRAW_END, 32'd2200, 32'd0);
    send_event(REQ_LOOP_END, 32'hFFFF_FFFF, 32'd0);
    send_event(REQ_LOOP_END, 32'd5, 32'hFFFF_FFF0);
    send_event(REQ_DRAW_BEGIN, 32'hAAAA_5555, 32'h5555_AAAA);
    send_event(REQ_DRAW_END, 32'h5555_AAAA, 32'hAAAA_5555);
    send_event(REQ_RESTART, 32'h8000_0000, 32'd0);
    send_event(REQ_LOOP_END, 32'h8000_0000, 32'h7FFF_FFFF);
    send_event(REQ_LOOP_END, 32'h8000_0400, 32'h8000_0000);
    clock_ms = 32'h8000_0400;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin stall_cfg = 16'd1;     rate_cfg = 16'd1;     skip_cfg = 16'd0;     max_step = 3; end
        1: begin stall_cfg = 16'd65535; rate_cfg = 16'd65535; skip_cfg = 16'd65535; max_step = 20000; end
        2: begin stall_cfg = 16'd0;     rate_cfg = 16'd0;     skip_cfg = 16'd0;     max_step = 2; end
        3: begin stall_cfg = 16'd16;    rate_cfg = 16'd5;     skip_cfg = 16'd10;    max_step = 8; end
        4: begin stall_cfg = 16'd1000;  rate_cfg = 16'd1000;  skip_cfg = 16'd50;    max_step = 60; end
        default: begin
          stall_cfg = CFG_W'($urandom_range(0, 400));
          rate_cfg  = CFG_W'($urandom_range(0, 400));
          skip_cfg  = CFG_W'($urandom_range(0, 200));
          max_step  = $urandom_range(1, 150);
        end
      endcase
      calm_src  = ($urandom_range(0, 3) == 0);
      calm_sink = ($urandom_range(0, 3) == 0);
      configure(stall_cfg, rate_cfg, skip_cfg);
      frame_idx = 0;
      while (events_sent < 25 + (p + 1) * 100) begin
        run_frame(p == 0 && frame_idx == 2);
        frame_idx++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
    $display("Covered %0d events and %0d checked results over %0d register settings,",
             events_sent, checked_count, settings_used);
    $display("with %0d rate window rollovers.", rollover_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("loop_stall_and_frame_rate_monitor_core verification clean");
    end else begin
      $display("loop_stall_and_frame_rate_monitor_core verification failed");
    end
    $finish;
  end

endmodule
